// ===== hw/rtl/rtpr_pkg.sv =====
// Shared types, constants and codes for the RTP reorder buffer.
package rtpr_pkg;

  localparam int NumStreamsDefault = 8;
  localparam int QueueDepthDefault = 512;

  localparam logic [14:0] SeqWindowReset  = 15'd1000;
  localparam logic [8:0]  MaxMixedReset   = 9'd16;
  localparam logic [8:0]  MaxOneFrameReset = 9'd384;

  localparam logic [1:0] CfgSeqWindow   = 2'd0;
  localparam logic [1:0] CfgMaxMixed    = 2'd1;
  localparam logic [1:0] CfgMaxOneFrame = 2'd2;

  localparam logic OpArrive = 1'b0;
  localparam logic OpPull   = 1'b1;

  localparam logic [1:0] StReleased = 2'd0;
  localparam logic [1:0] StNone     = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic        is_audio;
    logic [31:0] stream_id;
    logic [15:0] seq_number;
    logic [31:0] media_time;
    logic [31:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [31:0] out_seq_extended;
    logic        more_pending;
    logic        gap_skipped;
    logic [9:0]  late_dropped;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] tm;
    logic [31:0] handle;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SEARCH,
    S_ALLOC,
    S_EXTEND,
    S_PUSH_WR,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_SVC,
    S_SVC_RD,
    S_SVC_WAIT,
    S_SVC_CHK,
    S_POP_RD,
    S_POP_WAIT,
    S_POP_WR,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_RWAIT,
    S_DN_CMP,
    S_OUT
  } state_t;

endpackage

// ===== hw/rtl/rtpr_if.sv =====
// Valid/ready channel carrying one payload beat.
interface rtpr_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rtp_reorder_buffer.sv =====
// Top level of the RTP reorder buffer: stream table, per-stream heaps, sequencer.
// One item at a time. An audio beat is passed straight through; a pull with no stream
// answers none. An arrival takes the SSRC search over the active streams, the heap
// insert (sift-up) and a service pass; each pop in the service sifts down, all bound
// by the single read port of the entry RAM. Late drops add a full pop each.
// The result waits in an output register; the next beat is taken once it is gone.
module rtp_reorder_buffer #(
  parameter int NUM_STREAMS = rtpr_pkg::NumStreamsDefault,
  parameter int QUEUE_DEPTH = rtpr_pkg::QueueDepthDefault
) (
  input logic clk,
  input logic rst,
  rtpr_if.sink   in_ch,
  rtpr_if.source out_ch,
  rtpr_if.sink   cfg_ch
);
  import rtpr_pkg::*;

  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = QW + 1;
  localparam int AW = SW + QW;
  localparam int NW = $clog2(NUM_STREAMS + 1);

  logic [14:0] seq_window;
  logic [8:0]  max_mixed, max_one;

  logic [NUM_STREAMS-1:0] slot_valid;
  logic [31:0] slot_ssrc [NUM_STREAMS];
  logic [31:0] slot_last [NUM_STREAMS];
  logic [31:0] slot_newest [NUM_STREAMS];
  logic [SW-1:0] order [NUM_STREAMS];
  logic [CW-1:0] heap_count [NUM_STREAMS];
  logic [NW-1:0] active_count;

  entry_t mem [NUM_STREAMS*QUEUE_DEPTH];
  logic   mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  entry_t mem_wd, mem_rd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  state_t state;
  in_item_t  cur;
  out_item_t res;
  logic res_valid;
  logic [NW-1:0] k;
  logic [SW-1:0] s;
  logic [31:0] sx;
  logic [QW-1:0] i;
  logic [CW-1:0] n;
  entry_t ei, el;
  logic [9:0] late;
  logic gap;

  assign in_ch.ready = (state == S_IDLE) && !res_valid;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_window <= SeqWindowReset;
      max_mixed <= MaxMixedReset;
      max_one <= MaxOneFrameReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        CfgSeqWindow:   seq_window <= cfg_ch.data.data[14:0];
        CfgMaxMixed:    max_mixed <= cfg_ch.data.data[8:0];
        CfgMaxOneFrame: max_one <= cfg_ch.data.data[8:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] ks;
  logic [31:0] last_s, lastp1;
  logic signed [17:0] diff, thr;
  logic [31:0] sx_calc;
  logic [AW-1:0] base;
  logic [QW-1:0] par;
  logic [CW-1:0] lch, rch;
  logic [CW-1:0] lim;

  always_comb begin
    ks = order[k[SW-1:0]];
    last_s = slot_last[s];
    lastp1 = last_s + 32'd1;
    diff = $signed({2'b00, cur.seq_number}) - $signed({2'b00, last_s[15:0]});
    thr = $signed({3'b000, seq_window});
    sx_calc = {last_s[31:16], cur.seq_number};
    if (diff > thr) sx_calc = sx_calc - 32'h10000;
    if (diff < -thr) sx_calc = sx_calc + 32'h10000;
    base = {s, {QW{1'b0}}};
    par = (i - QW'(1)) >> 1;
    lch = {i, 1'b1};
    rch = lch + CW'(1);
    lim = CW'((mem_rd.tm == slot_newest[s]) ? max_one : max_mixed);
  end

  always_comb begin
    mem_ra = base;
    case (state)
      S_UP_RD:    mem_ra = base | AW'(par);
      S_UP_WAIT:  mem_ra = base | AW'(par);
      S_SVC_RD:   mem_ra = base;
      S_POP_RD:   mem_ra = base | AW'(n[QW-1:0]);
      S_POP_WAIT: mem_ra = base | AW'(n[QW-1:0]);
      S_DN_RD:    mem_ra = base | AW'(lch[QW-1:0]);
      S_DN_WAIT:  mem_ra = base | AW'(rch[QW-1:0]);
      S_DN_RWAIT: mem_ra = base | AW'(rch[QW-1:0]);
      default: mem_ra = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_we <= 1'b0;
      state <= S_IDLE;
      res_valid <= 1'b0;
      slot_valid <= '0;
      active_count <= '0;
      for (int j = 0; j < NUM_STREAMS; j++) begin
        order[j] <= SW'(j);
        heap_count[j] <= '0;
      end
    end else begin
      if (state != S_PUSH_WR && state != S_UP_CMP && state != S_POP_WR &&
          state != S_DN_RD && state != S_DN_CMP) mem_we <= 1'b0;
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cur <= in_ch.data;
            k <= '0;
            late <= '0;
            gap <= 1'b0;
            if (in_ch.data.opcode == OpPull) begin
              res <= '0;
              state <= S_SVC;
            end else if (in_ch.data.is_audio) begin
              res <= '{status: StReleased, out_handle: in_ch.data.packet_handle,
                       out_seq_extended: {16'd0, in_ch.data.seq_number},
                       more_pending: 1'b0, gap_skipped: 1'b0, late_dropped: 10'd0};
              state <= S_OUT;
            end else begin
              res <= '0;
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (k == active_count) begin
            state <= S_ALLOC;
          end else if (slot_ssrc[ks] == cur.stream_id) begin
            for (int j = 1; j < NUM_STREAMS; j++)
              if (NW'(j) <= k) order[j] <= order[j-1];
            order[0] <= ks;
            s <= ks;
            state <= S_EXTEND;
          end else begin
            k <= k + NW'(1);
          end
        end
        S_ALLOC: begin
          logic [SW-1:0] v;
          logic [NW-1:0] pos;
          pos = (active_count < NW'(NUM_STREAMS)) ? active_count : NW'(NUM_STREAMS - 1);
          v = order[pos[SW-1:0]];
          for (int j = 1; j < NUM_STREAMS; j++)
            if (NW'(j) <= pos) order[j] <= order[j-1];
          order[0] <= v;
          if (active_count < NW'(NUM_STREAMS)) active_count <= active_count + NW'(1);
          slot_valid[v] <= 1'b1;
          slot_ssrc[v] <= cur.stream_id;
          slot_last[v] <= '1;
          slot_newest[v] <= '0;
          heap_count[v] <= '0;
          s <= v;
          state <= S_EXTEND;
        end
        S_EXTEND: begin
          if (sx_calc == lastp1) begin
            slot_last[s] <= sx_calc;
            res.status <= StReleased;
            res.out_handle <= cur.packet_handle;
            res.out_seq_extended <= sx_calc;
            res.more_pending <= heap_count[s] != '0;
            state <= S_OUT;
          end else if (heap_count[s] >= CW'(QUEUE_DEPTH)) begin
            res.status <= StFull;
            state <= S_OUT;
          end else begin
            slot_newest[s] <= cur.media_time;
            sx <= sx_calc;
            i <= heap_count[s][QW-1:0];
            heap_count[s] <= heap_count[s] + CW'(1);
            ei <= '{seq: sx_calc, tm: cur.media_time, handle: cur.packet_handle};
            state <= S_PUSH_WR;
          end
        end
        S_PUSH_WR: begin
          if (i == '0) begin
            mem_we <= 1'b1; mem_wa <= base; mem_wd <= ei;
            state <= S_SVC;
          end else begin
            mem_we <= 1'b0;
            state <= S_UP_RD;
          end
        end
        S_UP_RD: state <= S_UP_WAIT;
        S_UP_WAIT: state <= S_UP_CMP;
        S_UP_CMP: begin
          mem_we <= 1'b1;
          mem_wa <= base | AW'(i);
          if (mem_rd.seq > ei.seq) begin
            mem_wd <= mem_rd;
            i <= par;
            state <= S_PUSH_WR;
          end else begin
            mem_wd <= ei;
            state <= S_SVC;
          end
        end
        S_SVC: begin
          cur.is_audio <= 1'b0;
          if (active_count == '0) begin
            res.status <= StNone;
            state <= S_OUT;
          end else begin
            s <= order[0];
            state <= S_SVC_RD;
          end
        end
        S_SVC_RD: begin
          if (heap_count[s] == '0) begin
            res.status <= StNone;
            res.late_dropped <= late;
            state <= S_OUT;
          end else begin
            state <= S_SVC_WAIT;
          end
        end
        S_SVC_WAIT: state <= S_SVC_CHK;
        S_SVC_CHK: begin
          if (mem_rd.seq <= last_s && last_s < 32'hffff0000) begin
            if (late != 10'd1023) late <= late + 10'd1;
            n <= heap_count[s] - CW'(1);
            heap_count[s] <= heap_count[s] - CW'(1);
            state <= S_POP_RD;
          end else if (mem_rd.seq == lastp1 || heap_count[s] > lim) begin
            gap <= !(mem_rd.seq == lastp1);
            res.status <= StReleased;
            res.out_handle <= mem_rd.handle;
            res.out_seq_extended <= mem_rd.seq;
            slot_last[s] <= mem_rd.seq;
            res.more_pending <= heap_count[s] > CW'(1);
            res.gap_skipped <= !(mem_rd.seq == lastp1);
            res.late_dropped <= late;
            cur.opcode <= OpPull;
            cur.is_audio <= 1'b1;
            n <= heap_count[s] - CW'(1);
            heap_count[s] <= heap_count[s] - CW'(1);
            state <= S_POP_RD;
          end else begin
            res.status <= StNone;
            res.late_dropped <= late;
            state <= S_OUT;
          end
        end
        S_POP_RD: begin
          if (n == '0) state <= S_POP_WR;
          else state <= S_POP_WAIT;
        end
        S_POP_WAIT: state <= S_POP_WR;
        S_POP_WR: begin
          if (n != '0) ei <= mem_rd;
          i <= '0;
          if (n <= CW'(1)) begin
            mem_we <= (n == CW'(1));
            mem_wa <= base;
            mem_wd <= mem_rd;
            state <= cur.is_audio ? S_OUT : S_SVC_RD;
          end else begin
            mem_we <= 1'b0;
            state <= S_DN_RD;
          end
        end
        S_DN_RD: begin
          if (lch >= n) begin
            mem_we <= 1'b1; mem_wa <= base | AW'(i); mem_wd <= ei;
            state <= cur.is_audio ? S_OUT : S_SVC_RD;
          end else begin
            mem_we <= 1'b0;
            state <= S_DN_WAIT;
          end
        end
        S_DN_WAIT: begin
          el <= mem_rd;
          state <= S_DN_RWAIT;
        end
        S_DN_RWAIT: state <= S_DN_CMP;
        S_DN_CMP: begin
          entry_t ec;
          logic [QW-1:0] ci;
          ec = el; ci = lch[QW-1:0];
          if (rch < n && mem_rd.seq < el.seq) begin
            ec = mem_rd; ci = rch[QW-1:0];
          end
          mem_we <= 1'b1;
          mem_wa <= base | AW'(i);
          if (ec.seq < ei.seq) begin
            mem_wd <= ec;
            i <= ci;
            state <= S_DN_RD;
          end else begin
            mem_wd <= ei;
            state <= cur.is_audio ? S_OUT : S_SVC_RD;
          end
        end
        S_OUT: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = gap ^ (|sx) ^ (|slot_valid);
endmodule
